/* src/rotdiv_pkg.sv */
// ----------------------------------------------------------------------------
// Rotating divider package
// Shared types, register indexes, divisor and auto-reset functions for the core.
// ----------------------------------------------------------------------------
`default_nettype none

package rotdiv_pkg;

    localparam int NUM_JACKS  = 8;
    localparam int COUNT_BITS = 6;
    localparam int JACK_BITS  = $clog2(NUM_JACKS);

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DOWNBEAT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GATE       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_32   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_16   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPREAD     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUTO_RESET = 3'd5;

    // Range codes, formed as {range_sel_16, range_sel_32}.
    localparam logic [1:0] RANGE_8  = 2'b00;
    localparam logic [1:0] RANGE_32 = 2'b01;
    localparam logic [1:0] RANGE_16 = 2'b10;
    localparam logic [1:0] RANGE_64 = 2'b11;

    localparam logic [3:0] SPREAD_TABLE [8] = '{4'd0, 4'd1, 4'd2, 4'd3,
                                                 4'd5, 4'd7, 4'd11, 4'd15};

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic downbeat;
        logic gate;
        logic range_32;
        logic range_16;
        logic spread;
        logic auto_reset;
    } t_cfg;

    // Per-lane control: which clock edge this beat carries and the fire modes.
    typedef struct packed {
        logic rise;
        logic fall;
        logic downbeat;
        logic gate;
    } t_lane_ctl;

    // Divisor of jack j for the given knob reading and range.
    function automatic t_count jack_divisor(input logic [7:0] knob,
                                            input logic [1:0] range,
                                            input logic spread,
                                            input logic [JACK_BITS-1:0] j);
        logic [6:0] s;
        logic [2:0] t;
        t_count     res;
        s   = '0;
        t   = j + knob[7:5];
        res = '0;
        if (spread) begin
            case (range)
                RANGE_16: begin
                    s   = {3'b000, j, 1'b0} + 7'd1 + {3'b000, knob[7:4]};
                    res = {2'b00, s[3:0]};
                end
                RANGE_32: begin
                    s   = {2'b00, j, 2'b00} + 7'd3 + {2'b00, knob[7:3]};
                    res = {1'b0, s[4:0]};
                end
                RANGE_64: begin
                    s   = {1'b0, j, 3'b000} + 7'd7 + {1'b0, knob[7:2]};
                    res = s[5:0];
                end
                default: res = {2'b00, SPREAD_TABLE[t]};
            endcase
        end else begin
            case (range)
                RANGE_16: begin
                    s   = {3'b000, knob[7:4]} + 7'd8 + {4'b0000, j};
                    res = {2'b00, s[3:0]};
                end
                RANGE_32: begin
                    s   = {2'b00, knob[7:3]} + 7'd16 + {4'b0000, j};
                    res = {1'b0, s[4:0]};
                end
                RANGE_64: begin
                    s   = {2'b00, knob[7:3]} + 7'd32 + {4'b0000, j};
                    res = s[5:0];
                end
                default: res = {3'b000, t};
            endcase
        end
        return res;
    endfunction

    // Auto-reset period in rising clock edges: twice the range.
    function automatic logic [8:0] auto_limit(input logic [1:0] range);
        logic [8:0] lim;
        case (range)
            RANGE_16: lim = 9'd32;
            RANGE_32: lim = 9'd64;
            RANGE_64: lim = 9'd128;
            default:  lim = 9'd16;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

/* src/rotdiv_if.sv */
// ----------------------------------------------------------------------------
// Rotating divider channels
// Valid/ready channels for the sample beats and the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface rotdiv_in_if;
    logic       valid;
    logic       ready;
    logic       clock_level;
    logic [7:0] rotate_knob;
    logic       reset_button;

    modport source (output valid, clock_level, rotate_knob, reset_button,
                    input ready);
    modport sink   (input valid, clock_level, rotate_knob, reset_button,
                    output ready);
endinterface

interface rotdiv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] jack_levels;
    logic       clock_led;

    modport source (output valid, jack_levels, clock_led, input ready);
    modport sink   (input valid, jack_levels, clock_led, output ready);
endinterface

`default_nettype wire

/* src/rotdiv_lane.sv */
// ----------------------------------------------------------------------------
// Rotating divider jack lane
// Next counter value and jack level of one output jack for one clock sample.
// ----------------------------------------------------------------------------
`default_nettype none

module rotdiv_lane
    import rotdiv_pkg::*;
(
    input  wire t_count    i_count,
    input  wire t_count    i_div,
    input  wire logic      i_level,
    input  wire t_lane_ctl i_ctl,
    output t_count         o_count,
    output logic           o_level
);

    logic [COUNT_BITS:0] inc_full;
    logic                wrap;
    t_count              counted;
    t_count              mid_rise;
    logic [COUNT_BITS:0] mid_fall_full;
    t_count              mid_fall;

    assign inc_full      = {1'b0, i_count} + 1'b1;
    assign wrap          = inc_full > {1'b0, i_div};
    assign counted       = wrap ? '0 : inc_full[COUNT_BITS-1:0];
    assign mid_rise      = {1'b0, i_div[COUNT_BITS-1:1]} + 1'b1;
    assign mid_fall_full = {1'b0, i_div} + 1'b1;
    assign mid_fall      = mid_fall_full[COUNT_BITS:1];

    always_comb begin
        o_count = i_count;
        o_level = i_level;
        if (i_ctl.rise) begin
            if (i_ctl.downbeat) begin
                if (i_count == '0) o_level = 1'b1;
                if (i_ctl.gate) begin
                    if (i_count == mid_rise) o_level = 1'b0;
                end else begin
                    o_count = counted;
                end
            end else if (i_ctl.gate) begin
                if (i_count == mid_rise) o_level = 1'b1;
                if (i_count == '0) o_level = 1'b0;
            end else begin
                o_count = counted;
                if (wrap) o_level = 1'b1;
            end
        end else if (i_ctl.fall) begin
            if (i_ctl.gate) begin
                if (i_count == mid_fall) o_level = ~i_ctl.downbeat;
                o_count = counted;
            end else begin
                o_level = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* src/rotating_eight_way_clock_divider_core.sv */
// ----------------------------------------------------------------------------
// Rotating eight-way clock divider core
// Eight jack dividers driven by sampled clock, knob and reset-button beats.
// ----------------------------------------------------------------------------
// Each input beat is one sample of the clock level, the rotate knob and the
// reset button; each accepted beat produces exactly one result beat carrying
// the eight jack levels and the clock LED. The core takes one beat per cycle
// sustained while results are taken: a beat lands in an input register, and
// once the result slot is free or emptying the eight jack lanes, the edge
// detector and the auto-reset counter all update together and the new levels
// are loaded into the result register. The input register can still take a
// beat while a result waits, and the core stalls only when both the input
// and result registers are full and the result is not taken. Configuration
// writes go to six one-bit registers selected by i_cfg_idx and should only
// happen while no beats are in flight. After reset all jacks are on and all
// counters are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rotating_eight_way_clock_divider_core
    import rotdiv_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    rotdiv_in_if.sink                    i_in,
    rotdiv_out_if.source                 o_out,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [0:0]              i_cfg_data
);

    // Configuration registers.
    t_cfg r_cfg;

    // Input register: one captured sample beat.
    logic       r_in_vld;
    logic       r_in_clk;
    logic [7:0] r_in_knob;
    logic       r_in_btn;

    // Divider state. The jack levels and LED double as the result payload:
    // they only change on a beat that also loads the result register.
    t_count     r_count [NUM_JACKS];
    logic       r_seen_high;
    logic       r_seen_low;
    logic       r_btn_held;
    logic [7:0] r_auto_cnt;
    logic [NUM_JACKS-1:0] r_jack_lvl;
    logic       r_led;
    logic       r_out_vld;

    logic       advance;
    logic [1:0] range;
    logic       btn_clear;
    logic       rise;
    logic       fall;
    t_lane_ctl  lane_ctl;
    logic [8:0] auto_next;
    logic       auto_clear;

    t_count     lane_div   [NUM_JACKS];
    t_count     lane_count [NUM_JACKS];
    t_count     n_count    [NUM_JACKS];
    logic [NUM_JACKS-1:0] n_jack_lvl;

    // A captured beat moves on whenever the result slot is free or emptying.
    // No beat is taken while reset is held.
    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_vld || advance);

    assign o_out.valid       = r_out_vld;
    assign o_out.jack_levels = r_jack_lvl;
    assign o_out.clock_led   = r_led;

    assign range     = {r_cfg.range_16, r_cfg.range_32};
    // The button clears on its rising edge, before the clock edge is handled.
    assign btn_clear = r_in_btn && !r_btn_held;
    assign rise      = r_in_clk && !r_seen_high;
    assign fall      = !r_in_clk && !r_seen_low;

    assign lane_ctl.rise     = rise;
    assign lane_ctl.fall     = fall;
    assign lane_ctl.downbeat = r_cfg.downbeat;
    assign lane_ctl.gate     = r_cfg.gate;

    // Auto-reset counts rising edges; on reaching twice the range it clears
    // every counter after the lanes have counted.
    assign auto_next  = {1'b0, r_auto_cnt} + 1'b1;
    assign auto_clear = rise && r_cfg.auto_reset && (auto_next >= auto_limit(range));

    for (genvar j = 0; j < NUM_JACKS; j++) begin : g_lane
        assign lane_div[j]   = jack_divisor(r_in_knob, range, r_cfg.spread,
                                            JACK_BITS'(j));
        assign lane_count[j] = btn_clear ? '0 : r_count[j];

        rotdiv_lane u_lane (
            .i_count (lane_count[j]),
            .i_div   (lane_div[j]),
            .i_level (r_jack_lvl[j]),
            .i_ctl   (lane_ctl),
            .o_count (n_count[j]),
            .o_level (n_jack_lvl[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DOWNBEAT:   r_cfg.downbeat   <= i_cfg_data[0];
                CFG_GATE:       r_cfg.gate       <= i_cfg_data[0];
                CFG_RANGE_32:   r_cfg.range_32   <= i_cfg_data[0];
                CFG_RANGE_16:   r_cfg.range_16   <= i_cfg_data[0];
                CFG_SPREAD:     r_cfg.spread     <= i_cfg_data[0];
                CFG_AUTO_RESET: r_cfg.auto_reset <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_clk  <= i_in.clock_level;
            r_in_knob <= i_in.rotate_knob;
            r_in_btn  <= i_in.reset_button;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_JACKS; j++) begin
                r_count[j] <= '0;
            end
            r_seen_high <= 1'b0;
            r_seen_low  <= 1'b0;
            r_btn_held  <= 1'b0;
            r_auto_cnt  <= '0;
            r_jack_lvl  <= '1;
            r_led       <= 1'b0;
        end else if (advance) begin
            for (int j = 0; j < NUM_JACKS; j++) begin
                r_count[j] <= auto_clear ? '0 : n_count[j];
            end
            r_jack_lvl  <= n_jack_lvl;
            r_btn_held  <= r_in_btn;
            r_seen_high <= r_in_clk;
            r_seen_low  <= !r_in_clk;
            if (rise) begin
                r_led <= 1'b1;
                if (r_cfg.auto_reset) begin
                    r_auto_cnt <= auto_clear ? '0 : auto_next[7:0];
                end
            end else if (fall) begin
                r_led <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
